### hw/rtl/cbs_pkg.sv
// Types and constants for the cubic Bezier sampler.
`timescale 1ns / 1ps
package cbs_pkg;
	localparam int COORD_W = 16;
	localparam int T_FRAC = 16;
	localparam int T_W = T_FRAC + 1;
	localparam int STEPS_W = 6;
	localparam int CFG_IDX_W = 1;
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = DIFF_W + T_W + 1;
	localparam int SHR_W = PROD_W - T_FRAC;
	localparam int SUM_W = SHR_W + 1;

	localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;
	localparam logic [STEPS_W-1:0] STEPS_RST = STEPS_W'(63);
	localparam logic [T_W-1:0] TSTEP_RST = T_W'(1040);

	localparam logic [CFG_IDX_W-1:0] CFG_STEPS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TSTEP = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t in_x;
		coord_t in_y;
		coord_t in_z;
		logic   clear_curve;
	} pt_word_t;

	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		coord_t out_z;
		logic   last_sample;
	} smp_word_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_ACC  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	typedef enum logic [2:0] {
		L_Q0  = 3'd0,
		L_Q1  = 3'd1,
		L_Q2  = 3'd2,
		L_R0  = 3'd3,
		L_R1  = 3'd4,
		L_OUT = 3'd5
	} lerp_t;
endpackage

### hw/rtl/cubic_bezier_sampler.sv
// Cubic Bezier segment sampler: de Casteljau evaluation on one shared lerp unit.
//
// channel  dir  handshake          word
// pt       in   pt_valid/pt_stall  pt_data  (in_x, in_y, in_z, clear_curve)
// smp      out  smp_valid/smp_stall smp_data (out_x, out_y, out_z, last_sample)
// cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// A point that does not complete a segment is taken in the idle state with no stall.
// A completing point starts steps+1 samples: each sample is 3 coordinates
// times 6 lerps, each a multiply state then a round/add/saturate state, on the one
// multiplier, then an output state that loads the output register.
// pt_stall is high while a segment is evaluated; smp_stall holds the sequencer
// in its output state. Reset clears control and config registers, not data registers.
`timescale 1ns / 1ps
module cubic_bezier_sampler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pt_valid,
	output logic                                pt_stall,
	input  cbs_pkg::pt_word_t                   pt_data,
	output logic                                smp_valid,
	input  logic                                smp_stall,
	output cbs_pkg::smp_word_t                  smp_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cbs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cbs_pkg::T_W-1:0]             cfg_data
);
	import cbs_pkg::*;

	localparam logic signed [PROD_W-1:0] RND = PROD_W'(1) << (T_FRAC - 1);
	localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 << (COORD_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

	state_t               state_q;
	lerp_t                li_q;
	logic [1:0]           c_q;
	logic [1:0]           phase_q;
	logic [STEPS_W-1:0]   cfg_steps_q;
	logic [T_W-1:0]       cfg_tstep_q;
	logic [STEPS_W-1:0]   steps_q;
	logic [STEPS_W-1:0]   k_q;
	logic [T_W-1:0]       tcur_q;
	coord_t               win_q [4][3];
	coord_t               q0_q, q1_q, q2_q, r0_q, r1_q;
	coord_t               res_q [3];
	logic signed [PROD_W-1:0] prod_q;
	logic                 smp_valid_q;
	smp_word_t            smp_data_q;

	coord_t               op_a, op_b;
	coord_t               p0, p1, p2, p3;
	logic [T_W-1:0]       t_cur;
	logic signed [DIFF_W-1:0] diff;
	logic signed [T_W:0]  t_sig;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] rnd;
	logic signed [SUM_W-1:0]  sum;
	coord_t               lerp_res;
	logic                 pt_take;
	logic                 out_free;
	logic                 last_k;
	logic [T_W:0]         t_next;

	assign cfg_ready = 1'b1;
	assign pt_stall = (state_q != ST_IDLE);
	assign pt_take = pt_valid && !pt_stall;
	assign smp_valid = smp_valid_q;
	assign smp_data = smp_data_q;
	assign out_free = !smp_valid_q || !smp_stall;
	assign last_k = (k_q == steps_q);
	assign t_cur = last_k ? T_ONE : tcur_q;
	assign t_next = {1'b0, tcur_q} + {1'b0, cfg_tstep_q};

	assign p0 = win_q[0][c_q];
	assign p1 = win_q[1][c_q];
	assign p2 = win_q[2][c_q];
	assign p3 = win_q[3][c_q];

	always_comb begin
		case (li_q)
			L_Q0: begin op_a = p0; op_b = p1; end
			L_Q1: begin op_a = p1; op_b = p2; end
			L_Q2: begin op_a = p2; op_b = p3; end
			L_R0: begin op_a = q0_q; op_b = q1_q; end
			L_R1: begin op_a = q1_q; op_b = q2_q; end
			L_OUT: begin op_a = r0_q; op_b = r1_q; end
			default: begin op_a = p0; op_b = p1; end
		endcase
	end

	assign diff = DIFF_W'(op_b) - DIFF_W'(op_a);
	assign t_sig = $signed({1'b0, t_cur});
	assign prod = PROD_W'(diff) * PROD_W'(t_sig);
	assign rnd = prod_q + RND;
	assign sum = SUM_W'(op_a) + SUM_W'($signed(rnd[PROD_W-1:T_FRAC]));

	always_comb begin
		if (sum > SAT_MAX) begin
			lerp_res = COORD_W'(SAT_MAX);
		end else if (sum < SAT_MIN) begin
			lerp_res = COORD_W'(SAT_MIN);
		end else begin
			lerp_res = sum[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_steps_q <= STEPS_RST;
			cfg_tstep_q <= TSTEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_STEPS: cfg_steps_q <= cfg_data[STEPS_W-1:0];
				CFG_TSTEP: cfg_tstep_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pt_take) begin
			if (pt_data.clear_curve) begin
				win_q[0] <= '{pt_data.in_x, pt_data.in_y, pt_data.in_z};
			end else begin
				win_q[phase_q] <= '{pt_data.in_x, pt_data.in_y, pt_data.in_z};
			end
		end else if (state_q == ST_OUT && out_free && last_k) begin
			win_q[0] <= win_q[3];
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod;
		end
		if (state_q == ST_ACC) begin
			case (li_q)
				L_Q0: q0_q <= lerp_res;
				L_Q1: q1_q <= lerp_res;
				L_Q2: q2_q <= lerp_res;
				L_R0: r0_q <= lerp_res;
				L_R1: r1_q <= lerp_res;
				L_OUT: res_q[c_q] <= lerp_res;
				default: ;
			endcase
		end
		if (state_q == ST_OUT && out_free) begin
			smp_data_q <= '{res_q[0], res_q[1], res_q[2], last_k};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 2'd0;
			li_q <= L_Q0;
			c_q <= 2'd0;
			k_q <= '0;
			steps_q <= STEPS_W'(1);
			tcur_q <= '0;
			smp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				smp_valid_q <= 1'b1;
			end else if (smp_valid_q && !smp_stall) begin
				smp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pt_take) begin
						if (pt_data.clear_curve) begin
							phase_q <= 2'd1;
						end else if (phase_q == 2'd3) begin
							steps_q <= (cfg_steps_q == '0) ? STEPS_W'(1) : cfg_steps_q;
							k_q <= '0;
							tcur_q <= '0;
							c_q <= 2'd0;
							li_q <= L_Q0;
							state_q <= ST_MUL;
						end else begin
							phase_q <= phase_q + 2'd1;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (li_q == L_OUT) begin
						li_q <= L_Q0;
						if (c_q == 2'd2) begin
							state_q <= ST_OUT;
						end else begin
							c_q <= c_q + 2'd1;
							state_q <= ST_MUL;
						end
					end else begin
						li_q <= lerp_t'(li_q + 3'd1);
						state_q <= ST_MUL;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						c_q <= 2'd0;
						if (last_k) begin
							phase_q <= 2'd1;
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + STEPS_W'(1);
							tcur_q <= (t_next > {1'b0, T_ONE}) ? T_ONE : t_next[T_W-1:0];
							state_q <= ST_MUL;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_t_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tcur_q <= T_ONE)
		else $error("t accumulator above one");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (k_q <= steps_q))
		else $error("sample index past step count");

	a_seg_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free && last_k) |=>
		(state_q == ST_IDLE && phase_q == 2'd1 && smp_valid && smp_data.last_sample))
		else $error("segment end not committed");

	a_no_smp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !smp_valid) |=> (!smp_valid || $past(pt_take) == 1'b0))
		else $error("word emitted from idle");
endmodule
